>>> src/pn3_pkg.sv
// Package for the 3-D gradient noise core: formats, hash codes and the
// permutation table. No dependencies; used by every module of the block.
package pn3_pkg;

  // Fixed formats of the stream fields
  localparam int COORD_W      = 24;
  localparam int CELL_W       = 8;
  localparam int NOISE_W      = 19;
  localparam int IN_TDATA_W   = 3 * COORD_W;
  localparam int OUT_TDATA_W  = 24;
  localparam int DEF_FRAC_BITS = 16;

  // Gradient selection codes on the low four hash bits
  localparam logic [3:0] HASH_X_LIM = 4'd8;
  localparam logic [3:0] HASH_Y_LIM = 4'd4;
  localparam logic [3:0] HASH_XY_A  = 4'd12;
  localparam logic [3:0] HASH_XY_B  = 4'd13;

  // Lattice permutation, indexed modulo 256
  localparam logic [7:0] PERM_ROM [256] = '{
    8'd151, 8'd160, 8'd137, 8'd91,  8'd90,  8'd15,  8'd131, 8'd13,
    8'd201, 8'd95,  8'd96,  8'd53,  8'd194, 8'd233, 8'd7,   8'd225,
    8'd140, 8'd36,  8'd103, 8'd30,  8'd69,  8'd142, 8'd8,   8'd99,
    8'd37,  8'd240, 8'd21,  8'd10,  8'd23,  8'd190, 8'd6,   8'd148,
    8'd247, 8'd120, 8'd234, 8'd75,  8'd0,   8'd26,  8'd197, 8'd62,
    8'd94,  8'd252, 8'd219, 8'd203, 8'd117, 8'd35,  8'd11,  8'd32,
    8'd57,  8'd177, 8'd33,  8'd88,  8'd237, 8'd149, 8'd56,  8'd87,
    8'd174, 8'd20,  8'd125, 8'd136, 8'd171, 8'd168, 8'd68,  8'd175,
    8'd74,  8'd165, 8'd71,  8'd134, 8'd139, 8'd48,  8'd27,  8'd166,
    8'd77,  8'd146, 8'd158, 8'd231, 8'd83,  8'd111, 8'd229, 8'd122,
    8'd60,  8'd211, 8'd133, 8'd230, 8'd220, 8'd105, 8'd92,  8'd41,
    8'd55,  8'd46,  8'd245, 8'd40,  8'd244, 8'd102, 8'd143, 8'd54,
    8'd65,  8'd25,  8'd63,  8'd161, 8'd1,   8'd216, 8'd80,  8'd73,
    8'd209, 8'd76,  8'd132, 8'd187, 8'd208, 8'd89,  8'd18,  8'd169,
    8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86,
    8'd164, 8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3,   8'd64,
    8'd52,  8'd217, 8'd226, 8'd250, 8'd124, 8'd123, 8'd5,   8'd202,
    8'd38,  8'd147, 8'd118, 8'd126, 8'd255, 8'd82,  8'd85,  8'd212,
    8'd207, 8'd206, 8'd59,  8'd227, 8'd47,  8'd16,  8'd58,  8'd17,
    8'd182, 8'd189, 8'd28,  8'd42,  8'd223, 8'd183, 8'd170, 8'd213,
    8'd119, 8'd248, 8'd152, 8'd2,   8'd44,  8'd154, 8'd163, 8'd70,
    8'd221, 8'd153, 8'd101, 8'd155, 8'd167, 8'd43,  8'd172, 8'd9,
    8'd129, 8'd22,  8'd39,  8'd253, 8'd19,  8'd98,  8'd108, 8'd110,
    8'd79,  8'd113, 8'd224, 8'd232, 8'd178, 8'd185, 8'd112, 8'd104,
    8'd218, 8'd246, 8'd97,  8'd228, 8'd251, 8'd34,  8'd242, 8'd193,
    8'd238, 8'd210, 8'd144, 8'd12,  8'd191, 8'd179, 8'd162, 8'd241,
    8'd81,  8'd51,  8'd145, 8'd235, 8'd249, 8'd14,  8'd239, 8'd107,
    8'd49,  8'd192, 8'd214, 8'd31,  8'd181, 8'd199, 8'd106, 8'd157,
    8'd184, 8'd84,  8'd204, 8'd176, 8'd115, 8'd121, 8'd50,  8'd45,
    8'd127, 8'd4,   8'd150, 8'd254, 8'd138, 8'd236, 8'd205, 8'd93,
    8'd222, 8'd114, 8'd67,  8'd29,  8'd24,  8'd72,  8'd243, 8'd141,
    8'd128, 8'd195, 8'd78,  8'd66,  8'd215, 8'd61,  8'd156, 8'd180
  };

  function automatic logic [7:0] perm_lookup(input logic [7:0] idx);
    return PERM_ROM[idx];
  endfunction

endpackage

>>> src/perlin_noise_3d_core.sv
// Top level of the 3-D gradient noise core: stream ports, fade weights,
// blend levels and output skid stage. Depends on pn3_pkg, pn3_hash, pn3_fade and pn3_lerp.
//
// Takes one point per clock while in_tready is high and returns one signed
// noise value per point, in order. An accepted point passes through four
// stages of corner hashing and gradient products (the fade weights are built
// in three stages alongside), two stages for each of the x, y and z blend
// levels, and the output register. Throughput is one point per cycle whatever
// the data while the skid register is empty. A second output register takes
// one more result when the sink stalls, so in_tready drops only in the cycle
// after a stalled result meets a new one, and comes back as soon as that result is taken.
module perlin_noise_3d_core import pn3_pkg::*; #(
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // x_coord[23:0], y_coord[47:24], z_coord[71:48]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // noise_value[18:0], zeros[23:19]
);

  localparam int F  = FRAC_BITS;
  localparam int CW = F + 3;

  logic en;
  logic [COORD_W-1:0] x_c, y_c, z_c;

  assign x_c = in_tdata[COORD_W-1:0];
  assign y_c = in_tdata[2*COORD_W-1:COORD_W];
  assign z_c = in_tdata[3*COORD_W-1:2*COORD_W];

  // Corner values
  logic                 hv;
  logic signed [CW-1:0] corner [8];

  pn3_hash #(.FRAC_BITS(F)) u_hash (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .v_i      (in_tvalid),
    .x_i      (x_c),
    .y_i      (y_c),
    .z_i      (z_c),
    .v_o      (hv),
    .corner_o (corner)
  );

  // Fade weights per axis
  logic [F:0] fx, fy, fz;

  pn3_fade #(.FRAC_BITS(F)) u_fade_x (.clk(clk), .en(en), .t_i(x_c[F-1:0]), .w_o(fx));
  pn3_fade #(.FRAC_BITS(F)) u_fade_y (.clk(clk), .en(en), .t_i(y_c[F-1:0]), .w_o(fy));
  pn3_fade #(.FRAC_BITS(F)) u_fade_z (.clk(clk), .en(en), .t_i(z_c[F-1:0]), .w_o(fz));

  // Align weights with the blend level that uses them
  logic [F:0] fx_d_r;
  logic [F:0] fy_d_r [3];
  logic [F:0] fz_d_r [5];

  always_ff @(posedge clk) begin
    if (en) begin
      fx_d_r    <= fx;
      fy_d_r[0] <= fy;
      fz_d_r[0] <= fz;
      for (int i = 1; i < 3; i++) fy_d_r[i] <= fy_d_r[i-1];
      for (int i = 1; i < 5; i++) fz_d_r[i] <= fz_d_r[i-1];
    end
  end

  // Blend along x, then y, then z
  logic                 xv, yv, zv;
  logic signed [CW-1:0] xval [4];
  logic signed [CW-1:0] yval [2];
  logic signed [CW-1:0] zval [1];

  pn3_lerp #(.FRAC_BITS(F), .PAIRS(4)) u_lerp_x (
    .clk(clk), .rst_n(rst_n), .en(en), .v_i(hv), .w_i(fx_d_r),
    .val_i(corner), .v_o(xv), .val_o(xval)
  );

  pn3_lerp #(.FRAC_BITS(F), .PAIRS(2)) u_lerp_y (
    .clk(clk), .rst_n(rst_n), .en(en), .v_i(xv), .w_i(fy_d_r[2]),
    .val_i(xval), .v_o(yv), .val_o(yval)
  );

  pn3_lerp #(.FRAC_BITS(F), .PAIRS(1)) u_lerp_z (
    .clk(clk), .rst_n(rst_n), .en(en), .v_i(yv), .w_i(fz_d_r[4]),
    .val_i(yval), .v_o(zv), .val_o(zval)
  );

  // Output register plus skid register
  logic               out_v_r, sk_v_r;
  logic [NOISE_W-1:0] out_d_r, sk_d_r;
  logic [NOISE_W-1:0] res;

  assign res = NOISE_W'(zval[0]);
  assign en  = !sk_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      sk_v_r  <= 1'b0;
    end else if (out_tready || !out_v_r) begin
      if (sk_v_r) begin
        out_v_r <= 1'b1;
        sk_v_r  <= 1'b0;
      end else begin
        out_v_r <= zv;
      end
    end else if (zv) begin
      // output held: the arriving result parks in the skid register
      sk_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_tready || !out_v_r) begin
      out_d_r <= sk_v_r ? sk_d_r : res;
    end else if (!sk_v_r) begin
      sk_d_r <= res;
    end
  end

  assign in_tready  = en;
  assign out_tvalid = out_v_r;
  assign out_tdata  = {{(OUT_TDATA_W-NOISE_W){1'b0}}, out_d_r};

endmodule

>>> src/pn3_hash.sv
// Corner hashing and gradient dot products, four register stages.
// Depends on pn3_pkg (permutation table, gradient codes).
module pn3_hash import pn3_pkg::*; #(
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         v_i,
  input  logic [COORD_W-1:0]           x_i,
  input  logic [COORD_W-1:0]           y_i,
  input  logic [COORD_W-1:0]           z_i,
  output logic                         v_o,
  output logic signed [FRAC_BITS+2:0]  corner_o [8]
);

  localparam int F  = FRAC_BITS;
  localparam int CW = F + 3;

  // Cell indexes and offsets of the incoming point
  logic [CELL_W-1:0] ix, iy, iz;
  assign ix = CELL_W'((x_i >> F) & COORD_W'(8'hFF));
  assign iy = CELL_W'((y_i >> F) & COORD_W'(8'hFF));
  assign iz = CELL_W'((z_i >> F) & COORD_W'(8'hFF));

  logic             v1_r, v2_r, v3_r, v4_r;
  logic [7:0]       hx_r  [2];
  logic [7:0]       hxy_r [4];
  logic [3:0]       h_r   [8];
  logic [7:0]       iy1_r;
  logic [7:0]       iz1_r, iz2_r;
  logic [F-1:0]     dx1_r, dy1_r, dz1_r;
  logic [F-1:0]     dx2_r, dy2_r, dz2_r;
  logic [F-1:0]     dx3_r, dy3_r, dz3_r;
  logic signed [CW-1:0] corner_r [8];

  // Gradient selected by the hash, dotted with the corner offset
  function automatic logic signed [CW-1:0] grad(input logic [3:0] h,
                                                input logic signed [F:0] gx,
                                                input logic signed [F:0] gy,
                                                input logic signed [F:0] gz);
    logic xu, yv;
    logic signed [CW-1:0] u, v;
    xu = (h < HASH_X_LIM) || (h == HASH_XY_A) || (h == HASH_XY_B);
    yv = (h < HASH_Y_LIM) || (h == HASH_XY_A) || (h == HASH_XY_B);
    u  = xu ? CW'(gx) : CW'(gy);
    v  = yv ? CW'(gy) : CW'(gz);
    if (h[0]) u = -u;
    if (h[1]) v = -v;
    return u + v;
  endfunction

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= v_i;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  // Hash chain: x, then y, then z, one table level per stage
  always_ff @(posedge clk) begin
    if (en) begin
      hx_r[0] <= perm_lookup(ix);
      hx_r[1] <= perm_lookup(8'(ix + 8'd1));
      iy1_r   <= iy;
      iz1_r   <= iz;
      dx1_r   <= x_i[F-1:0];
      dy1_r   <= y_i[F-1:0];
      dz1_r   <= z_i[F-1:0];

      for (int j = 0; j < 4; j++) begin
        hxy_r[j] <= perm_lookup(8'(hx_r[j % 2] + ((j / 2) == 1 ? 8'(iy1_r + 8'd1) : iy1_r)));
      end
      iz2_r <= iz1_r;
      dx2_r <= dx1_r;
      dy2_r <= dy1_r;
      dz2_r <= dz1_r;

      for (int k = 0; k < 8; k++) begin
        h_r[k] <= 4'(perm_lookup(8'(hxy_r[k % 4] + ((k / 4) == 1 ? 8'(iz2_r + 8'd1) : iz2_r))));
      end
      dx3_r <= dx2_r;
      dy3_r <= dy2_r;
      dz3_r <= dz2_r;

      // Offsets from the far corner are d - one, i.e. the sign bit set
      for (int k = 0; k < 8; k++) begin
        corner_r[k] <= grad(h_r[k],
                            (k % 2) == 1       ? signed'({1'b1, dx3_r}) : signed'({1'b0, dx3_r}),
                            ((k / 2) % 2) == 1 ? signed'({1'b1, dy3_r}) : signed'({1'b0, dy3_r}),
                            (k / 4) == 1       ? signed'({1'b1, dz3_r}) : signed'({1'b0, dz3_r}));
      end
    end
  end

  assign v_o      = v4_r;
  assign corner_o = corner_r;

endmodule

>>> src/pn3_fade.sv
// Fade curve 6t^5 - 15t^4 + 10t^3 in nested form, three register stages.
// Depends on pn3_pkg for the default fraction width.
module pn3_fade import pn3_pkg::*; #(
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [FRAC_BITS-1:0] t_i,
  output logic [FRAC_BITS:0]   w_o
);

  localparam int F  = FRAC_BITS;
  localparam int AW = F + 5;
  localparam int PW = 2 * F + 6;
  localparam longint ONE = 64'sd1 <<< F;
  localparam logic signed [AW-1:0] ONE15 = AW'(15 * ONE);
  localparam logic signed [AW-1:0] ONE10 = AW'(10 * ONE);
  localparam logic signed [AW-1:0] ONE_S = AW'(ONE);

  logic signed [F:0]    ts;
  logic signed [AW-1:0] a_c;
  logic [2*F-1:0]       tt_p;
  logic signed [PW-1:0] at_p;
  logic [F-1:0]         t1_r, t2_r, tsq_r;
  logic signed [AW-1:0] at_r, c_r;
  logic [2*F-1:0]       t3_p;
  logic signed [AW-1:0] b_c;
  logic signed [PW-1:0] c_p;
  logic signed [PW-1:0] w_p;
  logic signed [AW-1:0] w_c;
  logic [F:0]           w_r;

  // Stage 1: t^2 and (6t - 15) * t
  assign ts   = signed'({1'b0, t_i});
  assign a_c  = (AW'(ts) <<< 2) + (AW'(ts) <<< 1) - ONE15;
  assign tt_p = {{F{1'b0}}, t_i} * {{F{1'b0}}, t_i};
  assign at_p = a_c * ts;

  // Stage 2: t^3 and (at + 10) * t
  assign t3_p = {{F{1'b0}}, tsq_r} * {{F{1'b0}}, t1_r};
  assign b_c  = at_r + ONE10;
  assign c_p  = b_c * signed'({1'b0, t1_r});

  // Stage 3: c * t^3, clamped to [0, one]
  assign w_p = c_r * signed'({1'b0, t2_r});
  assign w_c = w_p[F+AW-1:F];

  always_ff @(posedge clk) begin
    if (en) begin
      t1_r  <= t_i;
      tsq_r <= tt_p[2*F-1:F];
      at_r  <= at_p[F+AW-1:F];
      t2_r  <= t3_p[2*F-1:F];
      c_r   <= c_p[F+AW-1:F];
      if (w_c < 0) begin
        w_r <= '0;
      end else if (w_c > ONE_S) begin
        w_r <= (F+1)'(ONE);
      end else begin
        w_r <= w_c[F:0];
      end
    end
  end

  assign w_o = w_r;

endmodule

>>> src/pn3_lerp.sv
// One level of the trilinear blend: PAIRS lerps a + w*(b - a), two stages.
// Depends on pn3_pkg for the default fraction width.
module pn3_lerp import pn3_pkg::*; #(
  parameter int FRAC_BITS = DEF_FRAC_BITS,
  parameter int PAIRS     = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         v_i,
  input  logic [FRAC_BITS:0]           w_i,
  input  logic signed [FRAC_BITS+2:0]  val_i [2*PAIRS],
  output logic                         v_o,
  output logic signed [FRAC_BITS+2:0]  val_o [PAIRS]
);

  localparam int F  = FRAC_BITS;
  localparam int CW = F + 3;
  localparam int DW = F + 4;
  localparam int PW = 2 * F + 6;

  logic                 v1_r, v2_r;
  logic signed [PW-1:0] prod_r [PAIRS];
  logic signed [CW-1:0] base_r [PAIRS];
  logic signed [CW-1:0] res_r  [PAIRS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= v_i;
      v2_r <= v1_r;
    end
  end

  // Stage 1: weight times difference; stage 2: floor shift and add
  always_ff @(posedge clk) begin
    if (en) begin
      for (int p = 0; p < PAIRS; p++) begin
        prod_r[p] <= signed'({1'b0, w_i}) * (DW'(val_i[2*p+1]) - DW'(val_i[2*p]));
        base_r[p] <= val_i[2*p];
        res_r[p]  <= base_r[p] + prod_r[p][F+CW-1:F];
      end
    end
  end

  assign v_o   = v2_r;
  assign val_o = res_r;

endmodule

>>> src/pn3_checker.sv
// Port-level checks for the noise core, bound to the top level.
// Depends on pn3_pkg for the stream widths.
module pn3_checker import pn3_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic [IN_TDATA_W-1:0]  in_tdata,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed or dropped");

  // Reset empties both output registers
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("output stage not empty after reset");

  // Input is held off only while a result waits
  a_ready_low: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with no result pending");

  // Input stalls only after the sink stalled a result
  a_ready_fell: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_tready) |-> $past(out_tvalid && !out_tready))
    else $error("input stalled without an output stall");

  // Padding above the noise value stays zero
  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_TDATA_W-1:NOISE_W] == '0)
    else $error("nonzero padding in out_tdata");

endmodule

bind perlin_noise_3d_core pn3_checker u_pn3_checker (.*);
